@@ sv/hdc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the humidity drift correction block
package hdc_pkg;

	localparam int WINDOW_LENGTH = 300;
	localparam int FRACTION_BITS = 16;

	localparam int DATA_W  = 24;
	localparam int GAIN_W  = 24;
	localparam int OUT_W   = 23;
	localparam int IN_TDATA_W  = 4 * DATA_W;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_TUSER_W = 1;

	// difference held in the ring, clamped to +/-0.5
	localparam int DIFF_W = FRACTION_BITS + 1;
	localparam int HALF_CODE = 2 ** (FRACTION_BITS - 1);

	localparam int ADDR_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
	localparam int SUM_W  = $clog2(WINDOW_LENGTH) + FRACTION_BITS + 1;
	localparam int PROD_W = GAIN_W + SUM_W;
	localparam int MAG_W  = PROD_W - 1;
	localparam int ADD_W  = MAG_W + 1;
	localparam int T_W    = ADD_W - FRACTION_BITS;
	localparam int R_W    = T_W - $clog2(WINDOW_LENGTH) + 1;
	localparam int RES_W  = T_W + 2;

	// half the divisor, for round to nearest with ties away from zero
	localparam logic [63:0] HALF_DEN_64 = (64'(WINDOW_LENGTH) << FRACTION_BITS) >> 1;
	localparam logic [63:0] RECIP_64 = (64'd1 << T_W) / 64'(WINDOW_LENGTH);

	localparam int FLOOR_CODE = ((2 ** FRACTION_BITS) + 50) / 100;
	localparam int OUT_MAX = (2 ** OUT_W) - 1;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(64'd1 << FRACTION_BITS);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] fast;
		logic                     fast_bad;
		logic                     gate;
		logic signed [DIFF_W-1:0] diff;
	} hdc_item_t;

endpackage

@@ sv/hdc_front.sv @@
`timescale 1ns / 1ps
// front end: takes input items, decides on a window update and clamps the difference
module hdc_front (
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [hdc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic [hdc_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	input  logic                               q_ready,
	output logic                               q_push,
	output hdc_pkg::hdc_item_t                 q_item
);

	localparam int DW = hdc_pkg::DATA_W;
	localparam int WW = hdc_pkg::DATA_W + 1;
	localparam logic signed [WW-1:0] HI = WW'(hdc_pkg::HALF_CODE);
	localparam logic signed [WW-1:0] LO = -HI;

	logic signed [DW-1:0] fast;
	logic signed [DW-1:0] refh;
	logic signed [DW-1:0] dew;
	logic signed [DW-1:0] air;
	logic                 fast_bad;
	logic                 ref_bad;
	logic signed [WW-1:0] diff_wide;
	logic signed [WW-1:0] diff_clamped;

	assign fast     = s_axis_tdata[DW-1:0];
	assign refh     = s_axis_tdata[2*DW-1:DW];
	assign dew      = s_axis_tdata[3*DW-1:2*DW];
	assign air      = s_axis_tdata[4*DW-1:3*DW];
	assign fast_bad = s_axis_tuser[0];
	assign ref_bad  = s_axis_tuser[1];

	assign diff_wide = WW'(refh) - WW'(fast);

	always_comb begin
		priority if (diff_wide < LO) begin
			diff_clamped = LO;
		end else if (diff_wide > HI) begin
			diff_clamped = HI;
		end else begin
			diff_clamped = diff_wide;
		end
	end

	assign s_axis_tready = q_ready;
	assign q_push        = s_axis_tvalid & q_ready;

	always_comb begin
		q_item.fast     = fast;
		q_item.fast_bad = fast_bad;
		q_item.gate     = (dew < air) & ~fast_bad & ~ref_bad;
		q_item.diff     = diff_clamped[hdc_pkg::DIFF_W-1:0];
	end

endmodule

@@ sv/hdc_queue.sv @@
`timescale 1ns / 1ps
// short queue of classified items between front and back
module hdc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hdc_pkg::hdc_item_t push_item,
	output logic               ready,
	input  logic               pop,
	output logic               valid,
	output hdc_pkg::hdc_item_t pop_item
);

	hdc_pkg::hdc_item_t entry_q [hdc_pkg::QDEPTH];
	logic [hdc_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hdc_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hdc_pkg::QCNT_W-1:0] count_q;
	logic do_pop;

	assign ready    = (count_q != hdc_pkg::QCNT_W'(hdc_pkg::QDEPTH));
	assign valid    = (count_q != '0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_pop   = pop & valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/hdc_back.sv @@
`timescale 1ns / 1ps
// back end: ring update, running sum, gain, rounded mean and output clamp
module hdc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hdc_pkg::GAIN_W-1:0]        cfg_wdata,
	input  logic                              q_valid,
	input  hdc_pkg::hdc_item_t                q_item,
	output logic                              q_pop,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [hdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic [hdc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

	localparam int WL    = hdc_pkg::WINDOW_LENGTH;
	localparam int AW    = hdc_pkg::ADDR_W;
	localparam int SW    = hdc_pkg::SUM_W;
	localparam int DFW   = hdc_pkg::DIFF_W;
	localparam int PW    = hdc_pkg::PROD_W;
	localparam int MW    = hdc_pkg::MAG_W;
	localparam int AD_W  = hdc_pkg::ADD_W;
	localparam int TW    = hdc_pkg::T_W;
	localparam int RW    = hdc_pkg::R_W;
	localparam int RSW   = hdc_pkg::RES_W;
	localparam int OW    = hdc_pkg::OUT_W;
	localparam int FB    = hdc_pkg::FRACTION_BITS;

	localparam logic [AW-1:0] POS_LAST = AW'(WL - 1);
	localparam logic [AD_W-1:0] HALF_DEN = AD_W'(hdc_pkg::HALF_DEN_64);
	localparam logic [RW-1:0] RECIP = RW'(hdc_pkg::RECIP_64);
	localparam logic [TW-1:0] WL_T = TW'(WL);
	localparam logic signed [RSW-1:0] FLOOR_RES = RSW'(hdc_pkg::FLOOR_CODE);
	localparam logic signed [RSW-1:0] MAX_RES = RSW'(hdc_pkg::OUT_MAX);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_SCALE = 3'd3;
	localparam logic [2:0] ST_RECIP = 3'd4;
	localparam logic [2:0] ST_FIX   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	logic [2:0] state_q;

	logic signed [DFW-1:0] ring_mem [WL];
	logic signed [DFW-1:0] rd_q;
	logic                  mem_re;
	logic                  mem_we;
	logic [AW-1:0]         pos_nxt;

	logic [AW-1:0]                pos_q;
	logic                         full_q;
	logic signed [SW-1:0]         sum_q;
	logic signed [hdc_pkg::GAIN_W-1:0] gain_q;
	hdc_pkg::hdc_item_t           item_q;
	logic signed [PW-1:0]         prod_q;
	logic [TW-1:0]                t_q;
	logic                         neg_q;
	logic [TW-1:0]                qe_q;
	logic signed [TW:0]           corr_q;
	logic                         out_valid_q;
	logic [OW-1:0]                out_data_q;
	logic                         out_bad_q;

	logic signed [DFW-1:0] old_diff;
	logic [MW-1:0]         mag;
	logic [AD_W-1:0]       mag_rnd;
	logic [TW+RW-1:0]      recip_prod;
	logic [TW-1:0]         rem;
	logic [TW-1:0]         quo;
	logic signed [RSW-1:0] res;
	logic [OW-1:0]         res_clamped;
	logic                  out_load;

	assign pos_nxt = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
	assign q_pop   = (state_q == ST_IDLE) & q_valid;
	assign mem_re  = q_pop & q_item.gate;
	assign mem_we  = (state_q == ST_READ) & item_q.gate;

	// entries not yet written since reset read as zero until the ring has wrapped once
	assign old_diff = full_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[pos_q] <= item_q.diff;
		end
		if (mem_re) begin
			rd_q <= ring_mem[pos_nxt];
		end
	end

	assign mag     = prod_q[PW-1] ? MW'(-prod_q) : MW'(prod_q);
	assign mag_rnd = AD_W'(mag) + HALF_DEN;

	// reciprocal estimate is low by at most one
	assign recip_prod = (TW+RW)'(t_q) * (TW+RW)'(RECIP);
	assign rem = t_q - TW'(qe_q * WL_T);
	assign quo = (rem >= WL_T) ? qe_q + 1'b1 : qe_q;

	assign res = RSW'(item_q.fast) + RSW'(corr_q);

	always_comb begin
		priority if (res < FLOOR_RES) begin
			res_clamped = OW'(FLOOR_RES);
		end else if (res > MAX_RES) begin
			res_clamped = OW'(MAX_RES);
		end else begin
			res_clamped = res[OW-1:0];
		end
	end

	assign out_load = (state_q == ST_FIN) & (~out_valid_q | m_axis_tready);

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_MUL) begin
			prod_q <= gain_q * sum_q;
		end
		if (state_q == ST_SCALE) begin
			t_q   <= mag_rnd[AD_W-1:FB];
			neg_q <= prod_q[PW-1];
		end
		if (state_q == ST_RECIP) begin
			qe_q <= TW'(recip_prod[TW+RW-1:TW]);
		end
		if (state_q == ST_FIX) begin
			corr_q <= neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		end
		if (out_load) begin
			out_data_q <= item_q.fast_bad ? '0 : res_clamped;
			out_bad_q  <= item_q.fast_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			full_q      <= 1'b0;
			sum_q       <= '0;
			gain_q      <= hdc_pkg::GAIN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				gain_q <= cfg_wdata;
			end
			if (mem_re) begin
				pos_q <= pos_nxt;
			end
			if (mem_we) begin
				sum_q <= sum_q - SW'(old_diff) + SW'(item_q.diff);
				if (pos_q == '0) begin
					full_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_FIX;
				ST_FIX:   state_q <= ST_FIN;
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = hdc_pkg::OUT_TDATA_W'(out_data_q);
	assign m_axis_tuser  = out_bad_q;

endmodule

@@ sv/humidity_drift_correction.sv @@
`timescale 1ns / 1ps
// top level of the humidity drift correction block
// usage:
// - s_axis carries one sample per item: fast humidity, reference humidity, dewpoint and
//   air temperature in tdata, the two invalid flags in tuser
// - m_axis returns one corrected humidity per item, result_invalid in tuser
// - cfg_we / cfg_wdata write the correction gain (signed Q7.16), reset value 1.0
// - the front classifies an item in the cycle it is accepted and places it in a
//   four-entry queue, so input is taken at one item per cycle until the queue fills
// - the back sequencer works through each item in turn (ring read, sum update, gain
//   multiply, rounding, reciprocal divide, correction, clamp) and takes the next item
//   from the queue only once the last result has been loaded into the output register
// - reset empties the queue, clears the running sum and ring position and loads the
//   gain; the 300-entry ring needs no clearing pass, a wrap flag makes entries read
//   as zero until first written, so items are taken straight after reset
// - when m_axis_tready is low the finished result holds in the output register and the
//   back waits with the next result; the front keeps taking items until the queue is full
module humidity_drift_correction (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hdc_pkg::GAIN_W-1:0]        cfg_wdata,     // correction_gain
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// fast_humidity, reference_humidity, dewpoint, air_temperature
	input  logic [hdc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// fast_invalid, reference_invalid
	input  logic [hdc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// corrected_humidity, zero pad
	output logic [hdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	// result_invalid
	output logic [hdc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

	hdc_pkg::hdc_item_t push_item;
	hdc_pkg::hdc_item_t pop_item;
	logic push;
	logic q_ready;
	logic q_valid;
	logic q_pop;

	hdc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_ready       (q_ready),
		.q_push        (push),
		.q_item        (push_item)
	);

	hdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	hdc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.q_valid       (q_valid),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

@@ sv/hdc_checker.sv @@
`timescale 1ns / 1ps
// port checker for the humidity drift correction block, with its bind
module hdc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [hdc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input logic [hdc_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

	// an invalid result carries a zero humidity
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("invalid result with nonzero humidity");

	// a valid result never falls below the floor
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tdata[hdc_pkg::OUT_W-1:0] >= hdc_pkg::OUT_W'(hdc_pkg::FLOOR_CODE))
		else $error("result below floor");

	// pad bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[hdc_pkg::OUT_TDATA_W-1:hdc_pkg::OUT_W] == '0)
		else $error("pad bits set");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind humidity_drift_correction hdc_checker u_hdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
